/* hdl/assert_macros.svh */
// Assertion macros for the formatting list unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define FMLIST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
`define FMLIST_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define FMLIST_ASSERT(lbl, clk, rst_n, prop, msg)
`define FMLIST_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* hdl/fmlist_pkg.sv */
package fmlist_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int LEN_W = $clog2(DEPTH + 1);

    localparam logic [2:0] CMD_PUSH_ELEM  = 3'd0;
    localparam logic [2:0] CMD_PUSH_MARK  = 3'd1;
    localparam logic [2:0] CMD_CLEAR      = 3'd2;
    localparam logic [2:0] CMD_REMOVE     = 3'd3;
    localparam logic [2:0] CMD_FIND_FIRST = 3'd4;
    localparam logic [2:0] CMD_FIND_LAST  = 3'd5;
    localparam logic [2:0] CMD_FIND_TAG   = 3'd6;

    localparam logic [2:0] NS_HTML = 3'd1;
    localparam logic [3:0] DUP_LIMIT_RESET = 4'd3;

    typedef logic [2:0]  command_t;
    typedef logic [15:0] node_t;
    typedef logic [15:0] tag_t;
    typedef logic [2:0]  space_t;
    typedef logic [31:0] attrs_t;

    typedef struct packed {
        logic   is_marker;
        node_t  node;
        tag_t   tag;
        space_t space;
        attrs_t attrs;
    } entry_t;

    typedef struct packed {
        logic marker;
        logic node_hit;
        logic dup_hit;
        logic tag_hit;
    } match_t;

endpackage

/* hdl/fmlist_cmd_if.sv */
interface fmlist_cmd_if;
    logic                 valid;
    logic                 ready;
    fmlist_pkg::command_t command;
    fmlist_pkg::node_t    node_id;
    fmlist_pkg::tag_t     tag_id;
    fmlist_pkg::space_t   name_space;
    fmlist_pkg::attrs_t   attr_signature;

    modport source (
        output valid, command, node_id, tag_id, name_space, attr_signature,
        input  ready
    );
    modport sink (
        input  valid, command, node_id, tag_id, name_space, attr_signature,
        output ready
    );
endinterface

/* hdl/fmlist_res_if.sv */
interface fmlist_res_if;
    logic              valid;
    logic              ready;
    logic              found;
    logic [5:0]        position;
    fmlist_pkg::node_t found_node;
    logic [6:0]        list_length;
    logic              evicted;
    logic              full_error;

    modport source (
        output valid, found, position, found_node, list_length, evicted, full_error,
        input  ready
    );
    modport sink (
        input  valid, found, position, found_node, list_length, evicted, full_error,
        output ready
    );
endinterface

/* hdl/fmlist_match.sv */
module fmlist_match (
    input  fmlist_pkg::entry_t entry,
    input  fmlist_pkg::node_t  node_id,
    input  fmlist_pkg::tag_t   tag_id,
    input  fmlist_pkg::space_t name_space,
    input  fmlist_pkg::attrs_t attr_signature,
    output fmlist_pkg::match_t hit
);

    always_comb
    begin
        hit.marker   = entry.is_marker;
        hit.node_hit = !entry.is_marker && (entry.node == node_id);
        hit.dup_hit  = !entry.is_marker && (entry.tag == tag_id)
                       && (entry.space == name_space) && (entry.attrs == attr_signature);
        hit.tag_hit  = !entry.is_marker && (entry.tag == tag_id)
                       && (entry.space == fmlist_pkg::NS_HTML);
    end

endmodule

/* hdl/formatting_list_with_markers_unit.sv */
// An item that is done waits in its last state until the result register is free.
// Searches read the entry memory one entry per cycle from the top or the bottom;
// a removal then moves each entry above the gap down, one entry per cycle.
// One item is in work at a time; the result register lets the next item in early.
// Reset clears the length, the control state and sets dup_limit to 3; the entry
// memory is not cleared, as only entries below the length are read.
`include "assert_macros.svh"

module formatting_list_with_markers_unit (
    input  logic        clk,
    input  logic        rst_n,
    fmlist_cmd_if.sink  cmd,
    fmlist_res_if.source res,
    input  logic        dup_limit_we,
    input  logic [3:0]  dup_limit_wdata
);

    localparam int IDX_W = fmlist_pkg::IDX_W;
    localparam int LEN_W = fmlist_pkg::LEN_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_PUSH  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    fmlist_pkg::entry_t mem [fmlist_pkg::DEPTH];
    fmlist_pkg::entry_t rd_data_reg;
    fmlist_pkg::entry_t mem_wdata;
    fmlist_pkg::entry_t new_entry;
    fmlist_pkg::match_t hit;

    logic             mem_re;
    logic             mem_we;
    logic [IDX_W-1:0] mem_raddr;
    logic [IDX_W-1:0] mem_waddr;

    logic [2:0]       state_reg, state_next;
    logic [3:0]       dup_limit_reg;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] len_m1;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] earliest_reg, earliest_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    fmlist_pkg::node_t fnode_reg, fnode_next;
    logic             evicted_reg, evicted_next;
    logic             full_reg, full_next;
    logic             out_valid_reg, out_valid_next;
    logic             stop;
    logic             accept;
    logic             res_load;

    fmlist_pkg::command_t cmd_reg;
    fmlist_pkg::node_t    node_reg;
    fmlist_pkg::tag_t     tag_reg;
    fmlist_pkg::space_t   space_reg;
    fmlist_pkg::attrs_t   attrs_reg;

    logic              res_found_reg;
    logic [5:0]        res_pos_reg;
    fmlist_pkg::node_t res_fnode_reg;
    logic [6:0]        res_len_reg;
    logic              res_evicted_reg;
    logic              res_full_reg;
    logic [IDX_W+5:0]  pos_wide;
    logic [LEN_W+6:0]  len_wide;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign len_m1    = len_reg - 1'b1;
    assign pos_wide  = {6'b000000, pos_reg};
    assign len_wide  = {7'b0000000, len_reg};

    assign new_entry.is_marker = (cmd_reg == fmlist_pkg::CMD_PUSH_MARK);
    assign new_entry.node      = node_reg;
    assign new_entry.tag       = tag_reg;
    assign new_entry.space     = space_reg;
    assign new_entry.attrs     = attrs_reg;

    fmlist_match u_match (
        .entry          (rd_data_reg),
        .node_id        (node_reg),
        .tag_id         (tag_reg),
        .name_space     (space_reg),
        .attr_signature (attrs_reg),
        .hit            (hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        addr_next      = addr_reg;
        rem_next       = rem_reg;
        rd_idx_next    = rd_idx_reg;
        rd_valid_next  = rd_valid_reg;
        cnt_next       = cnt_reg;
        earliest_next  = earliest_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        fnode_next     = fnode_reg;
        evicted_next   = evicted_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg && !res.ready;
        res_load       = 1'b0;
        stop           = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = addr_reg;
        mem_we         = 1'b0;
        mem_waddr      = rd_idx_reg - 1'b1;
        mem_wdata      = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next      = '0;
                    earliest_next = '0;
                    found_next    = 1'b0;
                    pos_next      = '0;
                    fnode_next    = '0;
                    evicted_next  = 1'b0;
                    full_next     = 1'b0;
                    rd_valid_next = 1'b0;
                    rem_next      = len_reg;
                    addr_next     = (cmd.command == fmlist_pkg::CMD_FIND_FIRST) ?
                                    '0 : len_m1[IDX_W-1:0];
                    case (cmd.command)
                        fmlist_pkg::CMD_PUSH_MARK:  state_next = S_PUSH;
                        fmlist_pkg::CMD_PUSH_ELEM,
                        fmlist_pkg::CMD_CLEAR,
                        fmlist_pkg::CMD_REMOVE,
                        fmlist_pkg::CMD_FIND_FIRST,
                        fmlist_pkg::CMD_FIND_LAST,
                        fmlist_pkg::CMD_FIND_TAG:   state_next = S_SCAN;
                        default:                    state_next = S_DONE;
                    endcase
                end
            end

            S_SCAN:
            begin
                if (rd_valid_reg)
                begin
                    case (cmd_reg)
                        fmlist_pkg::CMD_PUSH_ELEM:
                        begin
                            if (hit.marker)
                            begin
                                stop = 1'b1;
                            end
                            else if (hit.dup_hit)
                            begin
                                cnt_next      = cnt_reg + 1'b1;
                                earliest_next = rd_idx_reg;
                            end
                        end
                        fmlist_pkg::CMD_CLEAR:
                        begin
                            stop = hit.marker;
                        end
                        fmlist_pkg::CMD_REMOVE,
                        fmlist_pkg::CMD_FIND_FIRST,
                        fmlist_pkg::CMD_FIND_LAST:
                        begin
                            if (hit.node_hit)
                            begin
                                stop       = 1'b1;
                                found_next = 1'b1;
                                pos_next   = rd_idx_reg;
                            end
                        end
                        fmlist_pkg::CMD_FIND_TAG:
                        begin
                            if (hit.marker)
                            begin
                                stop = 1'b1;
                            end
                            else if (hit.tag_hit)
                            begin
                                stop       = 1'b1;
                                found_next = 1'b1;
                                pos_next   = rd_idx_reg;
                                fnode_next = rd_data_reg.node;
                            end
                        end
                        default:
                        begin
                            stop = 1'b1;
                        end
                    endcase
                end

                if (stop || (rem_reg == '0))
                begin
                    rd_valid_next = 1'b0;
                    case (cmd_reg)
                        fmlist_pkg::CMD_PUSH_ELEM:
                        begin
                            if ((cnt_next != '0) &&
                                ({4'b0000, cnt_next} >= {{LEN_W{1'b0}}, dup_limit_reg}))
                            begin
                                evicted_next = 1'b1;
                                addr_next    = earliest_next + 1'b1;
                                rem_next     = len_m1 - LEN_W'(earliest_next);
                                state_next   = S_SHIFT;
                            end
                            else
                            begin
                                state_next = S_PUSH;
                            end
                        end
                        fmlist_pkg::CMD_CLEAR:
                        begin
                            len_next   = stop ? LEN_W'(rd_idx_reg) : '0;
                            state_next = S_DONE;
                        end
                        fmlist_pkg::CMD_REMOVE:
                        begin
                            if (found_next)
                            begin
                                addr_next  = rd_idx_reg + 1'b1;
                                rem_next   = len_m1 - LEN_W'(rd_idx_reg);
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
                else
                begin
                    mem_re        = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = addr_reg;
                    rem_next      = rem_reg - 1'b1;
                    addr_next     = (cmd_reg == fmlist_pkg::CMD_FIND_FIRST) ?
                                    addr_reg + 1'b1 : addr_reg - 1'b1;
                end
            end

            S_SHIFT:
            begin
                mem_we = rd_valid_reg;
                if (rem_reg != '0)
                begin
                    mem_re        = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_idx_next   = addr_reg;
                    rem_next      = rem_reg - 1'b1;
                    addr_next     = addr_reg + 1'b1;
                end
                else
                begin
                    rd_valid_next = 1'b0;
                    len_next      = len_m1;
                    state_next    = (cmd_reg == fmlist_pkg::CMD_PUSH_ELEM) ? S_PUSH : S_DONE;
                end
            end

            S_PUSH:
            begin
                if (len_reg == LEN_W'(fmlist_pkg::DEPTH))
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = len_reg[IDX_W-1:0];
                    mem_wdata = new_entry;
                    len_next  = len_reg + 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    res_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dup_limit_reg <= fmlist_pkg::DUP_LIMIT_RESET;
            len_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            if (dup_limit_we)
            begin
                dup_limit_reg <= dup_limit_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        rem_reg      <= rem_next;
        rd_idx_reg   <= rd_idx_next;
        cnt_reg      <= cnt_next;
        earliest_reg <= earliest_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        fnode_reg    <= fnode_next;
        evicted_reg  <= evicted_next;
        full_reg     <= full_next;
        if (accept)
        begin
            cmd_reg   <= cmd.command;
            node_reg  <= cmd.node_id;
            tag_reg   <= cmd.tag_id;
            space_reg <= cmd.name_space;
            attrs_reg <= cmd.attr_signature;
        end
        if (res_load)
        begin
            res_found_reg   <= found_reg;
            res_pos_reg     <= pos_wide[5:0];
            res_fnode_reg   <= fnode_reg;
            res_len_reg     <= len_wide[6:0];
            res_evicted_reg <= evicted_reg;
            res_full_reg    <= full_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.found       = res_found_reg;
    assign res.position    = res_pos_reg;
    assign res.found_node  = res_fnode_reg;
    assign res.list_length = res_len_reg;
    assign res.evicted     = res_evicted_reg;
    assign res.full_error  = res_full_reg;

    `FMLIST_ASSERT(a_len_bound, clk, rst_n, len_reg <= LEN_W'(fmlist_pkg::DEPTH), "length beyond depth")
    `FMLIST_ASSERT(a_push_grows, clk, rst_n, (state_reg == S_PUSH && len_reg != LEN_W'(fmlist_pkg::DEPTH)) |=> (len_reg == $past(len_reg) + 1'b1), "push did not grow the list")
    `FMLIST_ASSERT_NEVER(a_rw_clash, clk, rst_n, mem_we && mem_re && (mem_waddr == mem_raddr), "read and write of one entry in one cycle")
    `FMLIST_ASSERT(a_read_in_walk, clk, rst_n, rd_valid_reg |-> (state_reg == S_SCAN || state_reg == S_SHIFT), "read data pending outside a walk")

endmodule

/* tb/sv/formatting_list_with_markers_unit_tb.sv */
`timescale 1ns / 100ps

module formatting_list_with_markers_unit_tb;

    import fmlist_pkg::*;

    localparam command_t CMD_UNUSED = 3'd7;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS [PHASES] = '{100, 50, 50, 100, 50, 40, 40, 60};
    localparam logic [3:0] PHASE_LIMIT [PHASES] =
        '{4'd15, 4'd1, 4'd0, 4'd1, 4'd7, 4'd2, 4'd15, 4'd3};
    localparam logic PHASE_FILL [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

    typedef struct packed {
        command_t command;
        node_t    node;
        tag_t     tag;
        space_t   space;
        attrs_t   attrs;
    } list_cmd_t;

    typedef struct packed {
        logic       found;
        logic [5:0] position;
        node_t      found_node;
        logic [6:0] list_length;
        logic       evicted;
        logic       full_error;
    } list_status_t;

    typedef struct packed {
        list_cmd_t    cmd;
        logic         given;
        list_status_t want;
    } directed_row_t;

    // Rows with given set carry a status that is plain to see; the rest go
    // through the predictor.
    localparam directed_row_t DIRECTED [21] = '{
        '{'{CMD_FIND_FIRST, 16'h0000, 16'h0000, 3'd0, 32'h0000_0000}, 1'b1,
          '{1'b0, 6'd0, 16'h0000, 7'd0, 1'b0, 1'b0}},
        '{'{CMD_CLEAR, 16'h0000, 16'h0000, 3'd0, 32'h0000_0000}, 1'b1,
          '{1'b0, 6'd0, 16'h0000, 7'd0, 1'b0, 1'b0}},
        '{'{CMD_REMOVE, 16'hFFFF, 16'h0000, 3'd0, 32'h0000_0000}, 1'b1,
          '{1'b0, 6'd0, 16'h0000, 7'd0, 1'b0, 1'b0}},
        '{'{CMD_UNUSED, 16'hFFFF, 16'hFFFF, 3'd7, 32'hFFFF_FFFF}, 1'b1,
          '{1'b0, 6'd0, 16'h0000, 7'd0, 1'b0, 1'b0}},
        '{'{CMD_PUSH_ELEM, 16'hFFFF, 16'hFFFF, 3'd7, 32'hFFFF_FFFF}, 1'b1,
          '{1'b0, 6'd0, 16'h0000, 7'd1, 1'b0, 1'b0}},
        '{'{CMD_PUSH_ELEM, 16'h0000, 16'h0000, 3'd0, 32'h0000_0000}, 1'b1,
          '{1'b0, 6'd0, 16'h0000, 7'd2, 1'b0, 1'b0}},
        '{'{CMD_PUSH_MARK, 16'h1234, 16'hFFFF, 3'd1, 32'hDEAD_BEEF}, 1'b1,
          '{1'b0, 6'd0, 16'h0000, 7'd3, 1'b0, 1'b0}},
        '{'{CMD_FIND_TAG, 16'h0000, 16'hFFFF, 3'd0, 32'h0000_0000}, 1'b1,
          '{1'b0, 6'd0, 16'h0000, 7'd3, 1'b0, 1'b0}},
        '{'{CMD_PUSH_ELEM, 16'h0010, 16'h00AA, NS_HTML, 32'h1234_5678}, 1'b1,
          '{1'b0, 6'd0, 16'h0000, 7'd4, 1'b0, 1'b0}},
        '{'{CMD_PUSH_ELEM, 16'h0011, 16'h00AA, NS_HTML, 32'h1234_5678}, 1'b0, '0},
        '{'{CMD_PUSH_ELEM, 16'h0012, 16'h00AA, NS_HTML, 32'h1234_5678}, 1'b0, '0},
        '{'{CMD_PUSH_ELEM, 16'h0013, 16'h00AA, NS_HTML, 32'h1234_5678}, 1'b0, '0},
        '{'{CMD_PUSH_ELEM, 16'h0020, 16'h00AA, 3'd2, 32'h1234_5678}, 1'b0, '0},
        '{'{CMD_FIND_TAG, 16'h0000, 16'h00AA, 3'd0, 32'h0000_0000}, 1'b0, '0},
        '{'{CMD_FIND_FIRST, 16'hFFFF, 16'h0000, 3'd0, 32'h0000_0000}, 1'b1,
          '{1'b1, 6'd0, 16'h0000, 7'd7, 1'b0, 1'b0}},
        '{'{CMD_FIND_LAST, 16'h0011, 16'h0000, 3'd0, 32'h0000_0000}, 1'b0, '0},
        '{'{CMD_FIND_LAST, 16'h0000, 16'h0000, 3'd0, 32'h0000_0000}, 1'b0, '0},
        '{'{CMD_REMOVE, 16'h0012, 16'h0000, 3'd0, 32'h0000_0000}, 1'b0, '0},
        '{'{CMD_CLEAR, 16'h0000, 16'h0000, 3'd0, 32'h0000_0000}, 1'b0, '0},
        '{'{CMD_CLEAR, 16'h0000, 16'h0000, 3'd0, 32'h0000_0000}, 1'b0, '0},
        '{'{CMD_FIND_TAG, 16'hFFFF, 16'h0000, 3'd0, 32'h0000_0000}, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic dup_limit_we;
    logic [3:0] dup_limit_wdata;
    logic idling;

    entry_t shadow_list [DEPTH];
    int unsigned shadow_len;
    logic [3:0] shadow_limit;
    entry_t styles [6];
    list_status_t status_queue [$];
    list_status_t due;
    int res_hold;
    int mismatches;

    fmlist_cmd_if cmd_bus ();
    fmlist_res_if res_bus ();

    formatting_list_with_markers_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd_bus),
        .res             (res_bus),
        .dup_limit_we    (dup_limit_we),
        .dup_limit_wdata (dup_limit_wdata)
    );

    always #4 clk = ~clk;

    function automatic void drop_entry(int unsigned idx);
        for (int unsigned i = idx; i + 1 < shadow_len; i++)
        begin
            shadow_list[i] = shadow_list[i + 1];
        end
        shadow_len--;
    endfunction

    function automatic logic append_entry(entry_t e);
        if (shadow_len >= DEPTH)
        begin
            return 1'b0;
        end
        shadow_list[shadow_len] = e;
        shadow_len++;
        return 1'b1;
    endfunction

    function automatic list_status_t apply_list_command(list_cmd_t c);
        list_status_t s;
        entry_t e;
        int unsigned hits;
        int unsigned oldest;
        logic popped_marker;
        s = '0;
        e = '0;
        hits = 0;
        oldest = 0;
        popped_marker = 1'b0;
        case (c.command)
            CMD_PUSH_ELEM:
            begin
                for (int i = int'(shadow_len) - 1; i >= 0; i--)
                begin
                    if (shadow_list[i].is_marker)
                        break;
                    if (shadow_list[i].tag == c.tag && shadow_list[i].space == c.space &&
                        shadow_list[i].attrs == c.attrs)
                    begin
                        hits++;
                        oldest = i;
                    end
                end
                if (hits > 0 && hits >= shadow_limit)
                begin
                    drop_entry(oldest);
                    s.evicted = 1'b1;
                end
                e.node = c.node;
                e.tag = c.tag;
                e.space = c.space;
                e.attrs = c.attrs;
                s.full_error = !append_entry(e);
            end
            CMD_PUSH_MARK:
            begin
                e.is_marker = 1'b1;
                s.full_error = !append_entry(e);
            end
            CMD_CLEAR:
            begin
                while (shadow_len != 0 && !popped_marker)
                begin
                    shadow_len--;
                    popped_marker = shadow_list[shadow_len].is_marker;
                end
            end
            CMD_REMOVE, CMD_FIND_LAST:
            begin
                for (int i = int'(shadow_len) - 1; i >= 0; i--)
                begin
                    if (!shadow_list[i].is_marker && shadow_list[i].node == c.node)
                    begin
                        s.found = 1'b1;
                        s.position = i[5:0];
                        if (c.command == CMD_REMOVE)
                            drop_entry(i);
                        break;
                    end
                end
            end
            CMD_FIND_FIRST:
            begin
                for (int i = 0; i < int'(shadow_len); i++)
                begin
                    if (!shadow_list[i].is_marker && shadow_list[i].node == c.node)
                    begin
                        s.found = 1'b1;
                        s.position = i[5:0];
                        break;
                    end
                end
            end
            CMD_FIND_TAG:
            begin
                for (int i = int'(shadow_len) - 1; i >= 0; i--)
                begin
                    if (shadow_list[i].is_marker)
                        break;
                    if (shadow_list[i].tag == c.tag && shadow_list[i].space == NS_HTML)
                    begin
                        s.found = 1'b1;
                        s.position = i[5:0];
                        s.found_node = shadow_list[i].node;
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        s.list_length = shadow_len[6:0];
        return s;
    endfunction

    function automatic node_t pick_node();
        int unsigned r;
        int unsigned idx;
        r = $urandom_range(0, 3);
        if (r < 2 && shadow_len != 0)
        begin
            idx = $urandom_range(0, shadow_len - 1);
            if (!shadow_list[idx].is_marker)
                return shadow_list[idx].node;
        end
        if (r == 3)
            return node_t'($urandom_range(0, 16'hFFFF));
        return node_t'($urandom_range(0, 15));
    endfunction

    function automatic void refresh_styles();
        foreach (styles[i])
        begin
            styles[i] = '0;
            styles[i].tag = tag_t'($urandom_range(0, 3));
            styles[i].space = ($urandom_range(0, 3) == 0) ? space_t'($urandom_range(0, 7))
                                                          : NS_HTML;
            styles[i].attrs = ($urandom_range(0, 1) == 0) ? attrs_t'($urandom())
                                                         : attrs_t'($urandom_range(0, 3));
        end
    endfunction

    function automatic list_cmd_t random_list_command(logic filling);
        list_cmd_t c;
        entry_t st;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (filling)
            c.command = (pick < 84) ? CMD_PUSH_ELEM :
                        (pick < 90) ? CMD_PUSH_MARK :
                        (pick < 94) ? CMD_FIND_TAG :
                        (pick < 97) ? CMD_REMOVE : CMD_FIND_FIRST;
        else
            c.command = (pick < 38) ? CMD_PUSH_ELEM :
                        (pick < 46) ? CMD_PUSH_MARK :
                        (pick < 51) ? CMD_CLEAR :
                        (pick < 63) ? CMD_REMOVE :
                        (pick < 73) ? CMD_FIND_FIRST :
                        (pick < 83) ? CMD_FIND_LAST :
                        (pick < 96) ? CMD_FIND_TAG : CMD_UNUSED;
        c.node = pick_node();
        if ($urandom_range(0, 3) != 0)
        begin
            st = styles[$urandom_range(0, 5)];
            c.tag = st.tag;
            c.space = st.space;
            c.attrs = st.attrs;
        end
        else
        begin
            c.tag = tag_t'($urandom_range(0, 16'hFFFF));
            c.space = space_t'($urandom_range(0, 7));
            c.attrs = attrs_t'($urandom());
        end
        if (c.command == CMD_FIND_TAG && shadow_len != 0 && $urandom_range(0, 4) < 3)
            c.tag = shadow_list[$urandom_range(0, shadow_len - 1)].tag;
        return c;
    endfunction

    task automatic issue_command(list_cmd_t c, logic given, list_status_t want);
        list_status_t s;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cmd_bus.valid <= 1'b1;
        cmd_bus.command <= c.command;
        cmd_bus.node_id <= c.node;
        cmd_bus.tag_id <= c.tag;
        cmd_bus.name_space <= c.space;
        cmd_bus.attr_signature <= c.attrs;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        s = apply_list_command(c);
        status_queue.push_back(given ? want : s);
    endtask

    task automatic settle_and_configure(logic [3:0] limit);
        cmd_bus.valid <= 1'b0;
        while (status_queue.size() != 0)
            @(posedge clk);
        dup_limit_we <= 1'b1;
        dup_limit_wdata <= limit;
        @(posedge clk);
        dup_limit_we <= 1'b0;
        shadow_limit = limit;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s: got %0h, expected %0h", what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (status_queue.size() == 0)
                report_mismatch("item with no result due, list_length",
                                res_bus.list_length, '0);
            else
            begin
                due = status_queue.pop_front();
                if (res_bus.found !== due.found)
                    report_mismatch("found", res_bus.found, due.found);
                if (res_bus.position !== due.position)
                    report_mismatch("position", res_bus.position, due.position);
                if (res_bus.found_node !== due.found_node)
                    report_mismatch("found_node", res_bus.found_node, due.found_node);
                if (res_bus.list_length !== due.list_length)
                    report_mismatch("list_length", res_bus.list_length, due.list_length);
                if (res_bus.evicted !== due.evicted)
                    report_mismatch("evicted", res_bus.evicted, due.evicted);
                if (res_bus.full_error !== due.full_error)
                    report_mismatch("full_error", res_bus.full_error, due.full_error);
            end
        end
        if (res_hold != 0)
        begin
            res_hold--;
            res_bus.ready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 4) == 0)
        begin
            res_hold = $urandom_range(0, 3);
            res_bus.ready <= 1'b0;
        end
        else
            res_bus.ready <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        list_cmd_t c;
        rst_n = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.command = CMD_PUSH_ELEM;
        cmd_bus.node_id = '0;
        cmd_bus.tag_id = '0;
        cmd_bus.name_space = '0;
        cmd_bus.attr_signature = '0;
        res_bus.ready = 1'b0;
        dup_limit_we = 1'b0;
        dup_limit_wdata = '0;
        idling = 1'b1;
        res_hold = 0;
        mismatches = 0;
        shadow_len = 0;
        shadow_limit = DUP_LIMIT_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[r])
        begin
            issue_command(DIRECTED[r].cmd, DIRECTED[r].given, DIRECTED[r].want);
        end

        // Fill phases push mostly elements so that the list reaches its full depth.
        for (int p = 0; p < PHASES; p++)
        begin
            settle_and_configure(PHASE_LIMIT[p]);
            refresh_styles();
            for (int k = 0; k < PHASE_ITEMS[p]; k++)
            begin
                if (k % 20 == 0)
                    idling = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
                c = random_list_command(PHASE_FILL[p]);
                issue_command(c, 1'b0, '0);
            end
        end

        cmd_bus.valid <= 1'b0;
        while (status_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
